>>> design/cpc_pkg.sv
// Package for the Cartesian/polar converter.
// Holds the kind codes, the CORDIC gain and arctangent table, and the saturation limit.
// Depends on nothing; the top level imports it.
`timescale 1ns / 1ps

package cpc_pkg;

  // Request kinds carried on in_tuser.
  localparam logic KIND_TO_POLAR = 1'b0;
  localparam logic KIND_TO_CART  = 1'b1;

  // Fraction bits kept below the coordinate unit inside the datapath.
  localparam int GUARD = 16;

  // CORDIC gain 0.60725293... in Q0.31.
  localparam logic signed [31:0] GAIN_Q31 = 32'sd1304065748;

  // atan(2^-i) as a 32-bit binary angle (2^32 is a full turn), truncated.
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41721,     32'd20860,
    32'd10430,     32'd5215,      32'd2607,      32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81,
    32'd40,        32'd20,        32'd10,        32'd5,
    32'd2,         32'd1,         32'd0,         32'd0
  };

  // Smallest L with L*L >= 2^(2w-1). Evaluated at elaboration only.
  function automatic logic [63:0] sat_limit(input int w);
    logic [63:0] t;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    t  = 64'd1 << (2 * w - 1);
    lo = 64'd0;
    hi = 64'd3037000500;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (mid * mid >= t) begin
        hi = mid;
      end else begin
        lo = mid + 64'd1;
      end
    end
    return lo;
  endfunction

endpackage

>>> design/cartesian_polar_converter.sv
// Cartesian/polar converter: a fully unrolled CORDIC pipeline, one rotation per stage.
// Depends on cpc_pkg for the kind codes, the gain, the arctangent table and the limit.
`timescale 1ns / 1ps

// Each request converts one point. With in_tuser at 0 the request carries x and y and the
// result carries the distance sqrt(x*x+y*y) and the binary angle atan2(y,x), where
// 2^(COORD_WIDTH-1) stands for pi and pi itself wraps to the most negative code; the origin
// gives distance 0 and angle 0. With in_tuser at 1 the request carries a distance and a
// binary angle and the result carries r*cos(a) and r*sin(a). Results are rounded half up and
// clamped to +-L, the smallest L with L*L >= 2^(2*COORD_WIDTH-1). The block keeps no state
// and gives exactly one result per request, in request order. It accepts one request every
// clock cycle unless the output is stalled. A request passes through the input register,
// the register of gain-scaled values, one register per CORDIC micro-rotation, and the
// output register, which is loaded after rounding and clamping. The whole pipeline
// advances together, so in_tready drops only while a finished result sits unaccepted
// on the output.
module cartesian_polar_converter
  import cpc_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int ITERATIONS  = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  // Request channel.
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // tdata fields from bit 0 up: coord_a, coord_b, zero fill to whole bytes.
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]          in_tdata,
  // tuser fields from bit 0 up: kind.
  input  logic                                        in_tuser,
  // Result channel.
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // tdata fields from bit 0 up: result_a, result_b, zero fill to whole bytes.
  output logic [((2*COORD_WIDTH+9)/8)*8-1:0]          out_tdata
);

  localparam int OW   = ((2 * COORD_WIDTH + 9) / 8) * 8;
  localparam int AW   = COORD_WIDTH + 1;          // coordinate after negation
  localparam int DW   = COORD_WIDTH + GUARD + 2;  // datapath width with growth margin
  localparam int PW   = AW + 32;                  // gain product width
  localparam int RW   = DW - GUARD;               // rounded coordinate width
  localparam int ASH  = 32 - COORD_WIDTH;         // angle accumulator to output shift
  localparam int PSH  = 31 - GUARD;               // gain product to datapath shift
  localparam logic [31:0] Z_HALF = (32'd1 << ASH) >> 1;
  localparam logic [31:0] Z_PI   = 32'h8000_0000;
  localparam logic signed [RW-1:0] SAT_LIM = RW'(sat_limit(COORD_WIDTH));
  localparam logic signed [DW-1:0] RND_HALF = DW'(1) <<< (GUARD - 1);

  // Global advance: the whole pipeline moves unless a result is held at the output.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------------------------------
  // Input stage: fold the point into the right half plane (vectoring) or the angle into the
  // front half turn (rotation), and flag the origin.
  // ---------------------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] a_in;
  logic signed [COORD_WIDTH-1:0] b_in;
  logic signed [AW-1:0]          a_nxt;
  logic signed [AW-1:0]          b_nxt;
  logic [31:0]                   z_nxt;
  logic                          zero_nxt;
  logic [31:0]                   z_ang;

  assign a_in  = $signed(in_tdata[COORD_WIDTH-1:0]);
  assign b_in  = $signed(in_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
  assign z_ang = 32'(unsigned'(b_in)) << ASH;

  always_comb begin
    a_nxt    = AW'(a_in);
    b_nxt    = AW'(b_in);
    z_nxt    = 32'd0;
    zero_nxt = 1'b0;
    if (in_tuser == KIND_TO_POLAR) begin
      zero_nxt = (a_in == '0) && (b_in == '0);
      if (a_in[COORD_WIDTH-1]) begin
        a_nxt = -AW'(a_in);
        b_nxt = -AW'(b_in);
        z_nxt = Z_PI;
      end
    end else begin
      z_nxt = z_ang;
      // Rear half turn: rotate by pi and flip the distance.
      if (z_ang[31] ^ z_ang[30]) begin
        z_nxt = z_ang ^ Z_PI;
        a_nxt = -AW'(a_in);
      end
    end
  end

  logic                 p_vld_r;
  logic                 p_kind_r;
  logic                 p_zero_r;
  logic signed [AW-1:0] p_a_r;
  logic signed [AW-1:0] p_b_r;
  logic [31:0]          p_z_r;

  // ---------------------------------------------------------------------------------------
  // Gain stage: pre-scale the coordinates by the CORDIC gain; for rotation, y starts at zero.
  // ---------------------------------------------------------------------------------------
  logic signed [PW-1:0] prod_a;
  logic signed [PW-1:0] prod_b;
  logic signed [DW-1:0] pre_a;
  logic signed [DW-1:0] pre_b;

  assign prod_a = p_a_r * GAIN_Q31;
  assign prod_b = p_b_r * GAIN_Q31;
  assign pre_a  = DW'(prod_a >>> PSH);
  assign pre_b  = (p_kind_r == KIND_TO_CART) ? '0 : DW'(prod_b >>> PSH);

  // ---------------------------------------------------------------------------------------
  // CORDIC stages: stage i applies micro-rotation i.
  // ---------------------------------------------------------------------------------------
  logic                 c_vld_r  [0:ITERATIONS];
  logic                 c_kind_r [0:ITERATIONS];
  logic                 c_zero_r [0:ITERATIONS];
  logic signed [DW-1:0] c_x_r    [0:ITERATIONS];
  logic signed [DW-1:0] c_y_r    [0:ITERATIONS];
  logic [31:0]          c_z_r    [0:ITERATIONS];

  logic signed [DW-1:0] c_x_nxt  [0:ITERATIONS-1];
  logic signed [DW-1:0] c_y_nxt  [0:ITERATIONS-1];
  logic [31:0]          c_z_nxt  [0:ITERATIONS-1];

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    logic                 sub;
    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] ys;
    // Vectoring drives y toward zero; rotation drives the residual angle toward zero.
    assign sub = (c_kind_r[i] == KIND_TO_CART) ? !c_z_r[i][31] : c_y_r[i][DW-1];
    assign xs  = c_x_r[i] >>> i;
    assign ys  = c_y_r[i] >>> i;
    assign c_x_nxt[i] = sub ? (c_x_r[i] - ys) : (c_x_r[i] + ys);
    assign c_y_nxt[i] = sub ? (c_y_r[i] + xs) : (c_y_r[i] - xs);
    assign c_z_nxt[i] = sub ? (c_z_r[i] - ATAN_TAB[i]) : (c_z_r[i] + ATAN_TAB[i]);
  end

  // ---------------------------------------------------------------------------------------
  // Output stage: round half up, clamp, and convert the angle accumulator.
  // ---------------------------------------------------------------------------------------
  logic signed [DW-1:0]          x_fin;
  logic signed [DW-1:0]          y_fin;
  logic [31:0]                   z_fin;
  logic signed [RW-1:0]          x_rnd;
  logic signed [RW-1:0]          y_rnd;
  logic signed [RW-1:0]          x_sat;
  logic signed [RW-1:0]          y_sat;
  logic [31:0]                   z_rnd;
  logic [COORD_WIDTH-1:0]        ang_q;
  logic signed [COORD_WIDTH:0]   res_a_nxt;
  logic signed [COORD_WIDTH:0]   res_b_nxt;

  assign x_fin = c_x_r[ITERATIONS];
  assign y_fin = c_y_r[ITERATIONS];
  assign z_fin = c_z_r[ITERATIONS];
  assign x_rnd = RW'((x_fin + RND_HALF) >>> GUARD);
  assign y_rnd = RW'((y_fin + RND_HALF) >>> GUARD);
  assign z_rnd = z_fin + Z_HALF;
  assign ang_q = COORD_WIDTH'(z_rnd >> ASH);

  always_comb begin
    x_sat = x_rnd;
    if (x_rnd > SAT_LIM) begin
      x_sat = SAT_LIM;
    end else if (x_rnd < -SAT_LIM) begin
      x_sat = -SAT_LIM;
    end
    y_sat = y_rnd;
    if (y_rnd > SAT_LIM) begin
      y_sat = SAT_LIM;
    end else if (y_rnd < -SAT_LIM) begin
      y_sat = -SAT_LIM;
    end
  end

  always_comb begin
    res_a_nxt = (COORD_WIDTH + 1)'(x_sat);
    if (c_kind_r[ITERATIONS] == KIND_TO_CART) begin
      res_b_nxt = (COORD_WIDTH + 1)'(y_sat);
    end else if (c_zero_r[ITERATIONS]) begin
      res_a_nxt = '0;
      res_b_nxt = '0;
    end else begin
      res_b_nxt = {ang_q[COORD_WIDTH-1], ang_q};
    end
  end

  logic                        out_valid_r;
  logic signed [COORD_WIDTH:0] out_a_r;
  logic signed [COORD_WIDTH:0] out_b_r;

  // ---------------------------------------------------------------------------------------
  // Registers. Valid bits reset; payload does not.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i <= ITERATIONS; i++) begin
        c_vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      p_vld_r     <= in_tvalid;
      c_vld_r[0]  <= p_vld_r;
      for (int i = 0; i < ITERATIONS; i++) begin
        c_vld_r[i+1] <= c_vld_r[i];
      end
      out_valid_r <= c_vld_r[ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_kind_r <= in_tuser;
      p_zero_r <= zero_nxt;
      p_a_r    <= a_nxt;
      p_b_r    <= b_nxt;
      p_z_r    <= z_nxt;

      c_kind_r[0] <= p_kind_r;
      c_zero_r[0] <= p_zero_r;
      c_x_r[0]    <= pre_a;
      c_y_r[0]    <= pre_b;
      c_z_r[0]    <= p_z_r;
      for (int i = 0; i < ITERATIONS; i++) begin
        c_kind_r[i+1] <= c_kind_r[i];
        c_zero_r[i+1] <= c_zero_r[i];
        c_x_r[i+1]    <= c_x_nxt[i];
        c_y_r[i+1]    <= c_y_nxt[i];
        c_z_r[i+1]    <= c_z_nxt[i];
      end

      out_a_r <= res_a_nxt;
      out_b_r <= res_b_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OW'({out_b_r, out_a_r});

endmodule

>>> design/cpc_checker.sv
// Port-level checker for the Cartesian/polar converter, bound to the top level.
// Depends on cartesian_polar_converter for its ports and COORD_WIDTH.
`timescale 1ns / 1ps

module cpc_checker #(
  parameter int COORD_WIDTH = 16
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [((2*COORD_WIDTH+9)/8)*8-1:0] out_tdata
);

  // A result held back by the consumer stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A held result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // A stalled result freezes the pipeline, so no new request may enter.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request accepted while output stalled");

  // An empty output register never blocks the request side.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("request side blocked with empty output");

endmodule

bind cartesian_polar_converter cpc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cpc_checker (.*);
